/* rtl/khs_pkg.sv */
// Package for the key hash slot block: transaction structs, constants and the
// byte-wide CRC-16 update function. No dependencies.
`default_nettype none

package khs_pkg;

  // Slot width and the CRC constants.
  localparam int unsigned SLOT_BITS = 14;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] SLOT_MASK   = 16'((32'd1 << SLOT_BITS) - 32'd1) & 16'h3FFF;
  localparam logic [7:0]  OPEN_BRACE  = 8'h7B;
  localparam logic [7:0]  CLOSE_BRACE = 8'h7D;

  // Progress of the hash tag search.
  typedef enum logic [1:0] {
    TAG_SEARCH = 2'd0,
    TAG_INSIDE = 2'd1,
    TAG_CLOSED = 2'd2
  } tag_phase_t;

  // One key byte per input transaction.
  typedef struct packed {
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last_byte;
  } khs_in_t;

  // One result per key.
  typedef struct packed {
    logic [13:0] hash_slot;
    logic        tag_used;
  } khs_out_t;

  // CRC-16/XMODEM update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/key_hash_slot_crc16_top.sv */
// Top level of the key hash slot block: input register, CRC engine and result
// register. Depends on khs_pkg and khs_slot_engine.
// A key's slot is registered when its last byte leaves the input register.
// Throughput: one key byte per cycle; the input register moves on while a
// result waits in the output register, and stalls only when both are full.
// Reset (rst_n, synchronous, active low) clears both valid flags and all CRC state.
`default_nettype none

module key_hash_slot_crc16_top
  import khs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire khs_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output khs_out_t      out_data
);

  khs_in_t  item_r;
  logic     item_vld_r, item_vld_nxt;
  logic     out_vld_r, out_vld_nxt;
  khs_out_t out_data_r;
  khs_out_t result;
  logic     out_free;
  logic     go;

  // An item leaves the input register unless it ends a key and the result
  // register is still occupied.
  assign out_free = !out_vld_r || out_ready;
  assign go       = item_vld_r && (!item_r.last_byte || out_free);
  assign in_ready = !item_vld_r || go;

  khs_slot_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item_r),
    .go     (go),
    .result (result)
  );

  // Valid flags of the two registers.
  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_ready) begin
      item_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (go && item_r.last_byte) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (go && item_r.last_byte) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/khs_slot_engine.sv */
// Running CRC state for the whole key and for its hash tag, with the tag
// search. Depends on khs_pkg.
`default_nettype none

module khs_slot_engine
  import khs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire khs_in_t  item,
  input  wire logic     go,
  output khs_out_t      result
);

  logic [15:0] crc_whole_r, crc_whole_nxt;
  logic [15:0] crc_tag_r, crc_tag_nxt;
  tag_phase_t  phase_r, phase_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic [15:0] crc_whole_upd, crc_tag_upd;
  tag_phase_t  phase_upd;
  logic        nonempty_upd;
  logic        use_tag;
  logic [15:0] crc_sel;

  // Absorb the byte into both CRCs and step the tag search.
  always_comb begin
    crc_whole_upd = crc_whole_r;
    crc_tag_upd   = crc_tag_r;
    phase_upd     = phase_r;
    nonempty_upd  = nonempty_r;
    if (item.byte_valid) begin
      crc_whole_upd = crc16_byte(crc_whole_r, item.key_byte);
      unique case (phase_r)
        TAG_SEARCH: begin
          if (item.key_byte == OPEN_BRACE) begin
            phase_upd = TAG_INSIDE;
          end
        end
        TAG_INSIDE: begin
          if (item.key_byte == CLOSE_BRACE) begin
            phase_upd = TAG_CLOSED;
          end else begin
            crc_tag_upd  = crc16_byte(crc_tag_r, item.key_byte);
            nonempty_upd = 1'b1;
          end
        end
        default: begin
          phase_upd = phase_r;
        end
      endcase
    end
  end

  // Pick the CRC that decides the slot.
  always_comb begin
    use_tag          = (phase_upd == TAG_CLOSED) && nonempty_upd;
    crc_sel          = use_tag ? crc_tag_upd : crc_whole_upd;
    result.hash_slot = 14'(crc_sel & SLOT_MASK);
    result.tag_used  = use_tag;
  end

  // The end of a key returns all state to its cleared value.
  always_comb begin
    crc_whole_nxt = crc_whole_r;
    crc_tag_nxt   = crc_tag_r;
    phase_nxt     = phase_r;
    nonempty_nxt  = nonempty_r;
    if (go) begin
      if (item.last_byte) begin
        crc_whole_nxt = '0;
        crc_tag_nxt   = '0;
        phase_nxt     = TAG_SEARCH;
        nonempty_nxt  = 1'b0;
      end else begin
        crc_whole_nxt = crc_whole_upd;
        crc_tag_nxt   = crc_tag_upd;
        phase_nxt     = phase_upd;
        nonempty_nxt  = nonempty_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_whole_r <= '0;
      crc_tag_r   <= '0;
      phase_r     <= TAG_SEARCH;
      nonempty_r  <= 1'b0;
    end else begin
      crc_whole_r <= crc_whole_nxt;
      crc_tag_r   <= crc_tag_nxt;
      phase_r     <= phase_nxt;
      nonempty_r  <= nonempty_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/key_hash_slot_crc16_top_tb.sv */
// Self-checking testbench for key_hash_slot_crc16_top: drives keys byte by byte and
// compares each hash slot with a CRC-16 prediction kept in the bench. Depends on khs_pkg.
`default_nettype none

module key_hash_slot_crc16_top_tb;
  import khs_pkg::*;

  localparam int KEY_ITEM_TARGET = 900;
  localparam int TAIL_ITEMS      = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  khs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  khs_out_t out_data;

  key_hash_slot_crc16_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Items waiting to be sent and slots waiting to be seen.
  khs_in_t  key_items_pending[$];
  khs_out_t expected_slots[$];
  int       items_queued = 0;
  int       fail_count = 0;
  int       sender_gap = 0;
  int       receiver_stall = 0;
  int       quiet_cycles = 0;
  logic     calm = 1'b0;

  // Shadow state of the slot calculation.
  logic [15:0] key_crc = '0;
  logic [15:0] tag_crc = '0;
  tag_phase_t  brace_phase = TAG_SEARCH;
  logic        tag_has_bytes = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // CRC-16/XMODEM, fed one message bit at a time from the top bit down.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        feedback;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = r[15] ^ data[i];
      r = {r[14:0], 1'b0};
      if (feedback) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Absorb one accepted byte; on the last one, queue the slot and clear the state.
  task automatic predict_slot(input khs_in_t item);
    khs_out_t    slot;
    logic [15:0] chosen;
    if (item.byte_valid) begin
      key_crc = crc_step(key_crc, item.key_byte);
      case (brace_phase)
        TAG_SEARCH: begin
          if (item.key_byte == OPEN_BRACE) brace_phase = TAG_INSIDE;
        end
        TAG_INSIDE: begin
          if (item.key_byte == CLOSE_BRACE) begin
            brace_phase = TAG_CLOSED;
          end else begin
            tag_crc = crc_step(tag_crc, item.key_byte);
            tag_has_bytes = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (item.last_byte) begin
      slot.tag_used = (brace_phase == TAG_CLOSED) && tag_has_bytes;
      chosen = slot.tag_used ? tag_crc : key_crc;
      chosen = chosen & SLOT_MASK;
      slot.hash_slot = chosen[13:0];
      expected_slots.insert(expected_slots.size(), slot);
      key_crc = '0;
      tag_crc = '0;
      brace_phase = TAG_SEARCH;
      tag_has_bytes = 1'b0;
    end
  endtask

  // Compare one result transaction with the oldest expected slot.
  task automatic compare_slot(input khs_out_t got);
    khs_out_t want;
    if (expected_slots.size() == 0) begin
      if (fail_count < 10) begin
        $display("unexpected result: slot %0d tag_used %0b", got.hash_slot, got.tag_used);
      end
      fail_count++;
    end else begin
      want = expected_slots.pop_front();
      if (got.hash_slot !== want.hash_slot || got.tag_used !== want.tag_used) begin
        if (fail_count < 10) begin
          $display("slot mismatch: expected slot %0d tag_used %0b, got slot %0d tag_used %0b",
                   want.hash_slot, want.tag_used, got.hash_slot, got.tag_used);
        end
        fail_count++;
      end
    end
  endtask

  task automatic add_item(input logic [7:0] b, input logic valid, input logic last);
    khs_in_t item;
    item.key_byte = b;
    item.byte_valid = valid;
    item.last_byte = last;
    key_items_pending.insert(key_items_pending.size(), item);
    items_queued++;
  endtask

  task automatic add_key(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_item(s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  // Braces turn up often so that tag handling is exercised in noisy keys too.
  function automatic logic [7:0] random_key_byte();
    case ($urandom_range(0, 7))
      0: return OPEN_BRACE;
      1: return CLOSE_BRACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed tagged keys with random content, the rest noise.
  task automatic add_random_keys();
    logic [7:0] key_bytes[$];
    int         body_len;
    logic       invalid_end;
    while (items_queued < KEY_ITEM_TARGET) begin
      key_bytes.delete();
      if ($urandom_range(0, 9) < 7) begin
        body_len = $urandom_range(0, 3);
        for (int i = 0; i < body_len; i++) key_bytes.insert(key_bytes.size(), random_key_byte());
        key_bytes.insert(key_bytes.size(), OPEN_BRACE);
        body_len = $urandom_range(0, 4);
        for (int i = 0; i < body_len; i++) begin
          key_bytes.insert(key_bytes.size(), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) != 0) key_bytes.insert(key_bytes.size(), CLOSE_BRACE);
        body_len = $urandom_range(0, 3);
        for (int i = 0; i < body_len; i++) key_bytes.insert(key_bytes.size(), random_key_byte());
      end else begin
        body_len = $urandom_range(0, 10);
        for (int i = 0; i < body_len; i++) key_bytes.insert(key_bytes.size(), random_key_byte());
      end
      invalid_end = (key_bytes.size() == 0) || ($urandom_range(0, 9) == 0);
      for (int i = 0; i < key_bytes.size(); i++) begin
        if ($urandom_range(0, 9) == 0) add_item(random_key_byte(), 1'b0, 1'b0);
        add_item(key_bytes[i], 1'b1, !invalid_end && i == key_bytes.size() - 1);
      end
      if (invalid_end) add_item(random_key_byte(), 1'b0, 1'b1);
    end
  endtask

  // Random switching between stretches with and without idling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) calm <= ~calm;
  end

  // Driver: one key byte per transaction, with bursts of idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      sender_gap <= 0;
    end else begin
      if (in_valid && in_ready) predict_slot(in_data);
      if (!in_valid || in_ready) begin
        if (sender_gap != 0) begin
          sender_gap <= sender_gap - 1;
          in_valid <= 1'b0;
        end else if (key_items_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && key_items_pending.size() >= TAIL_ITEMS &&
                     $urandom_range(0, 5) == 0) begin
          sender_gap <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_data <= key_items_pending.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls the result channel in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      receiver_stall <= 0;
    end else begin
      if (out_valid && out_ready) compare_slot(out_data);
      if (receiver_stall != 0) begin
        receiver_stall <= receiver_stall - 1;
        out_ready <= 1'b0;
      end else if (!calm && key_items_pending.size() >= TAIL_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
        receiver_stall <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Empty key, and a single all-ones byte.
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    // Empty tag: the whole key decides.
    add_key("{}");
    // Tag holding a single zero byte.
    add_item(OPEN_BRACE, 1'b1, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(CLOSE_BRACE, 1'b1, 1'b1);
    // An empty tag ends the search, so the later pair is ignored.
    add_key("{}{a}");
    // Unclosed tag, ended by an invalid item carrying the last mark.
    add_item(OPEN_BRACE, 1'b1, 1'b0);
    add_item("a", 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    // An invalid closing brace must not close the tag.
    add_item("a", 1'b1, 1'b0);
    add_item(OPEN_BRACE, 1'b1, 1'b0);
    add_item(CLOSE_BRACE, 1'b0, 1'b0);
    add_item("b", 1'b1, 1'b0);
    add_item(CLOSE_BRACE, 1'b1, 1'b0);
    add_item("c", 1'b1, 1'b1);
    // A closing brace before any opening one is ordinary.
    add_key("}{z}");
    add_random_keys();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (key_items_pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_slots.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
